>>> rtl/apf_pkg.sv
// shared types and constants for the articulation point finder
package apf_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int NODE_W = 6;
    localparam int CNT_W = 7;
    localparam logic [CNT_W-1:0] NO_PARENT = 7'd64;
    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;
    localparam logic REQ_EDGE = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;
    localparam logic [0:0] ADDR_NODE_COUNT = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROOT,
        ST_FETCH,
        ST_LOAD,
        ST_SCAN,
        ST_VISIT,
        ST_POP,
        ST_POPW,
        ST_ROOTEND,
        ST_EMIT,
        ST_CLEAR
    } apf_state_t;

    // controller to datapath
    typedef struct packed {
        logic edge_wr;
        logic root_init;
        logic root_next;
        logic root_push;
        logic fetch;
        logic load;
        logic scan;
        logic visit;
        logic pop;
        logic pop_wr;
        logic root_end;
        logic emit_load;
        logic clear_row;
    } apf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic root_done;
        logic root_visited;
        logic nb_found;
        logic stack_empty;
        logic emit_last;
        logic clear_done;
    } apf_sts_t;

endpackage

>>> rtl/articulation_point_finder_core.sv
// top level of the articulation point finder
// s_axis words: edge inserts (req_type 0) or a compute request (req_type 1).
// edge words are taken one per cycle while the block is idle and produce no output.
// a compute word drops s_axis_tready while a depth-first walk runs; following
// one adjacency bit goes through stack fetch, row load, scan and visit, and each
// node adds its pop and root handling, all before the first word.
// m_axis then gives one word per node in use, ascending, tlast on the final
// node, one per cycle while m_axis_tready is high; one result register holds
// each word until the receiver takes it, so a stall simply halts the output.
// after the last word is loaded, a clearing pass over all MAX_NODES rows
// wipes the adjacency matrix and marks; input is accepted again after that, even
// while the final word still waits.
// reset clears control state and runs the same clearing pass over all
// MAX_NODES rows before s_axis_tready first rises. the user writes node_count
// over apb (paddr[2] == 0) only while idle; the block does not enforce it.
module articulation_point_finder_core #(
    parameter int MAX_NODES = apf_pkg::MAX_NODES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // first_end, second_end, zero pad
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // node_index, is_critical, zero pad
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import apf_pkg::*;

    logic [CNT_W-1:0] node_count_reg;
    apf_cmd_t cmd;
    apf_sts_t sts;
    logic [5:0] first_end, second_end, res_node;
    logic res_crit, in_fire, edge_ok;
    logic [CNT_W-1:0] n_eff;

    assign pready = 1'b1;
    assign prdata = {25'd0, node_count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            node_count_reg <= NODE_COUNT_RST;
        else if (psel && penable && pwrite && paddr[2] == ADDR_NODE_COUNT)
            node_count_reg <= pwdata[CNT_W-1:0];
    end

    assign first_end  = s_axis_tdata[5:0];
    assign second_end = s_axis_tdata[11:6];
    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign n_eff = (node_count_reg == '0) ? 7'd1 :
                   (node_count_reg > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_reg;
    assign edge_ok = ({1'b0, first_end} < n_eff) && ({1'b0, second_end} < n_eff);

    apf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .in_compute (s_axis_tuser == REQ_COMPUTE),
        .in_edge_ok (edge_ok),
        .in_ready   (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .cmd        (cmd),
        .sts        (sts)
    );

    apf_datapath #(.MAX_NODES(MAX_NODES)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .node_count (node_count_reg),
        .first_end  (first_end),
        .second_end (second_end),
        .res_node   (res_node),
        .res_crit   (res_crit),
        .res_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, res_crit, res_node};

endmodule

>>> rtl/apf_datapath.sv
// adjacency matrix, node marks, walk stack and result register
module apf_datapath #(
    parameter int MAX_NODES = apf_pkg::MAX_NODES_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  apf_pkg::apf_cmd_t       cmd,
    output apf_pkg::apf_sts_t       sts,
    input  logic [apf_pkg::CNT_W-1:0] node_count,
    input  logic [5:0]              first_end,
    input  logic [5:0]              second_end,
    output logic [5:0]              res_node,
    output logic                    res_crit,
    output logic                    res_last
);
    import apf_pkg::*;

    localparam int IW = $clog2(MAX_NODES);
    localparam int SW = $clog2(MAX_NODES + 1);

    logic [63:0]       adj_mem [MAX_NODES];
    logic [NODE_W-1:0] depth_mem [MAX_NODES];
    logic [NODE_W-1:0] low_mem [MAX_NODES];
    logic [CNT_W-1:0]  par_mem [MAX_NODES];
    logic [IW-1:0]     stk_node_mem [MAX_NODES];
    logic [CNT_W-1:0]  stk_pos_mem [MAX_NODES];
    logic [MAX_NODES-1:0] visited_reg, crit_reg;

    logic [SW-1:0]     sp_reg;
    logic [CNT_W-1:0]  root_reg;
    logic [1:0]        rc_reg;
    logic [IW-1:0]     u_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [63:0]       row_reg;
    logic [NODE_W-1:0] du_reg, lu_reg;
    logic [CNT_W-1:0]  pu_reg;
    logic [NODE_W-1:0] dv_reg;
    logic [IW-1:0]     p_reg;
    logic [NODE_W-1:0] dp_reg, lp_reg;
    logic [CNT_W-1:0]  pp_reg;
    logic [CNT_W-1:0]  emit_reg;
    logic [IW-1:0]     clr_reg;
    logic [5:0]        res_node_reg;
    logic              res_crit_reg, res_last_reg;

    logic [CNT_W-1:0]  n_eff;
    logic [63:0]       active, cand;
    logic [6:0]        v_idx;
    logic [IW-1:0]     v;
    logic [SW-1:0]     sp_m1, sp_m2;

    always_comb
    begin
        if (node_count == '0)
            n_eff = 7'd1;
        else if (node_count > CNT_W'(MAX_NODES))
            n_eff = CNT_W'(MAX_NODES);
        else
            n_eff = node_count;
    end

    always_comb
    begin
        active = (n_eff >= 7'd64) ? '1 : ((64'd1 << n_eff[5:0]) - 64'd1);
        cand = row_reg & active & ~((64'd1 << pos_reg[5:0]) - 64'd1);
        if (pos_reg[6])
            cand = '0;
        v_idx = 7'd64;
        for (int b = 63; b >= 0; b--)
            if (cand[b])
                v_idx = 7'(b);
    end

    assign v = v_idx[IW-1:0];
    assign sp_m1 = sp_reg - SW'(1);
    assign sp_m2 = sp_reg - SW'(2);

    always_comb
    begin
        sts.root_done    = root_reg >= n_eff;
        sts.root_visited = visited_reg[root_reg[IW-1:0]];
        sts.nb_found     = v_idx < 7'd64;
        sts.stack_empty  = sp_reg == '0;
        sts.emit_last    = emit_reg + 7'd1 >= n_eff;
        sts.clear_done   = clr_reg == IW'(MAX_NODES - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg <= '0;
            crit_reg    <= '0;
            sp_reg      <= '0;
            root_reg    <= '0;
            rc_reg      <= '0;
            emit_reg    <= '0;
            clr_reg     <= '0;
        end
        else
        begin
            if (cmd.root_init)
            begin
                root_reg <= '0;
                emit_reg <= '0;
            end
            if (cmd.root_next)
                root_reg <= root_reg + 7'd1;
            if (cmd.root_push)
            begin
                visited_reg[root_reg[IW-1:0]] <= 1'b1;
                rc_reg <= '0;
                sp_reg <= SW'(1);
            end
            if (cmd.visit)
            begin
                if (!visited_reg[v])
                begin
                    if (u_reg == root_reg[IW-1:0] && rc_reg < 2'd2)
                        rc_reg <= rc_reg + 2'd1;
                    visited_reg[v] <= 1'b1;
                    if (sp_reg < SW'(MAX_NODES))
                        sp_reg <= sp_reg + SW'(1);
                end
            end
            if (cmd.pop_wr)
            begin
                sp_reg <= sp_m1;
                if (sp_m1 != '0 && pp_reg != NO_PARENT && lu_reg >= dp_reg)
                    crit_reg[p_reg] <= 1'b1;
            end
            if (cmd.root_end && rc_reg == 2'd2)
                crit_reg[root_reg[IW-1:0]] <= 1'b1;
            if (cmd.emit_load)
                emit_reg <= emit_reg + 7'd1;
            if (cmd.clear_row)
            begin
                if (sts.clear_done)
                begin
                    clr_reg     <= '0;
                    visited_reg <= '0;
                    crit_reg    <= '0;
                end
                else
                    clr_reg <= clr_reg + IW'(1);
            end
        end
    end

    // stack, node tables and matrix
    always_ff @(posedge clk)
    begin
        if (cmd.edge_wr)
        begin
            adj_mem[first_end[IW-1:0]][second_end] <= 1'b1;
            adj_mem[second_end[IW-1:0]][first_end] <= 1'b1;
        end
        if (cmd.clear_row)
        begin
            adj_mem[clr_reg] <= '0;
            par_mem[clr_reg] <= NO_PARENT;
        end
        if (cmd.root_push)
        begin
            depth_mem[root_reg[IW-1:0]] <= '0;
            low_mem[root_reg[IW-1:0]]   <= '0;
            par_mem[root_reg[IW-1:0]]   <= NO_PARENT;
            stk_node_mem[0] <= root_reg[IW-1:0];
            stk_pos_mem[0]  <= '0;
            u_reg   <= root_reg[IW-1:0];
            pos_reg <= '0;
        end
        if (cmd.fetch)
        begin
            u_reg   <= stk_node_mem[sp_m1[IW-1:0]];
            pos_reg <= stk_pos_mem[sp_m1[IW-1:0]];
        end
        if (cmd.load)
        begin
            row_reg <= adj_mem[u_reg];
            du_reg  <= depth_mem[u_reg];
            lu_reg  <= low_mem[u_reg];
            pu_reg  <= par_mem[u_reg];
        end
        if (cmd.scan)
        begin
            dv_reg <= depth_mem[v];
            p_reg  <= stk_node_mem[sp_m2[IW-1:0]];
        end
        if (cmd.visit)
        begin
            stk_pos_mem[sp_m1[IW-1:0]] <= v_idx + 7'd1;
            if (!visited_reg[v])
            begin
                par_mem[v]   <= CNT_W'(u_reg);
                depth_mem[v] <= du_reg + 6'd1;
                low_mem[v]   <= du_reg + 6'd1;
                if (sp_reg < SW'(MAX_NODES))
                begin
                    stk_node_mem[sp_reg[IW-1:0]] <= v;
                    stk_pos_mem[sp_reg[IW-1:0]]  <= '0;
                end
            end
            else if (CNT_W'(v) != pu_reg && dv_reg < lu_reg)
                low_mem[u_reg] <= dv_reg;
        end
        if (cmd.pop)
        begin
            dp_reg <= depth_mem[p_reg];
            lp_reg <= low_mem[p_reg];
            pp_reg <= par_mem[p_reg];
        end
        if (cmd.pop_wr && sp_m1 != '0 && lu_reg < lp_reg)
            low_mem[p_reg] <= lu_reg;
        if (cmd.emit_load)
        begin
            res_node_reg <= emit_reg[5:0];
            res_crit_reg <= crit_reg[emit_reg[IW-1:0]];
            res_last_reg <= sts.emit_last;
        end
    end

    assign res_node = res_node_reg;
    assign res_crit = res_crit_reg;
    assign res_last = res_last_reg;

endmodule

>>> rtl/apf_ctrl.sv
// sequencer for edge loading, walk, result output and clearing
module apf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              in_compute,
    input  logic              in_edge_ok,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output apf_pkg::apf_cmd_t cmd,
    input  apf_pkg::apf_sts_t sts
);
    import apf_pkg::*;

    apf_state_t state_reg, state_next;
    logic       ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    if (in_compute)
                    begin
                        cmd.root_init = 1'b1;
                        state_next = ST_ROOT;
                    end
                    else
                        cmd.edge_wr = in_edge_ok;
                end
            end
            ST_ROOT:
            begin
                if (sts.root_done)
                    state_next = ST_EMIT;
                else if (sts.root_visited)
                    cmd.root_next = 1'b1;
                else
                begin
                    cmd.root_push = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_FETCH:
            begin
                if (sts.stack_empty)
                    state_next = ST_ROOTEND;
                else
                begin
                    cmd.fetch = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                state_next = sts.nb_found ? ST_VISIT : ST_POP;
            end
            ST_VISIT:
            begin
                cmd.visit = 1'b1;
                state_next = ST_FETCH;
            end
            ST_POP:
            begin
                cmd.pop = 1'b1;
                state_next = ST_POPW;
            end
            ST_POPW:
            begin
                cmd.pop_wr = 1'b1;
                state_next = ST_FETCH;
            end
            ST_ROOTEND:
            begin
                cmd.root_end = 1'b1;
                cmd.root_next = 1'b1;
                state_next = ST_ROOT;
            end
            ST_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.emit_load = 1'b1;
                    ov_next = 1'b1;
                    if (sts.emit_last)
                        state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                cmd.clear_row = 1'b1;
                if (sts.clear_done)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

>>> rtl/apf_checker.sv
// port-level checks for the articulation point finder
module apf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");

    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken during result output");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[7])
        else $error("pad bit set");

    a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) && m_axis_tdata[5:0] != 6'd0 |-> $past(m_axis_tvalid))
        else $error("sequence does not start at node zero");
endmodule

bind articulation_point_finder_core apf_checker u_apf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
